// ===== rtl/sbim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbim_pkg - shared types and constants of the sketch bitmap block
// Stream widths, item modes, error codes, register indexes, the effective
// configuration bundle and the back-end sequencer states.
// ----------------------------------------------------------------------------
package sbim_pkg;

	localparam int S_TDATA_W  = 160;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 104;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int WORD_W     = 64;
	localparam int ERR_W      = 2;

	// kind of input item
	typedef enum logic [1:0] {
		MODE_HASH   = 2'd0,
		MODE_DIRECT = 2'd1,
		MODE_MERGE  = 2'd2,
		MODE_READ   = 2'd3
	} sbim_mode_t;

	// result status
	typedef enum logic [ERR_W-1:0] {
		ERR_OK     = 2'd0,
		ERR_BUCKET = 2'd1,
		ERR_WORD   = 2'd2
	} sbim_err_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INDEX_BITS = 1'b0,
		REG_PRECISION  = 1'b1
	} sbim_reg_t;

	// effective (clamped) shape of the sketch
	typedef struct packed {
		logic [4:0] ib;
		logic [6:0] prec;
	} sbim_cfg_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_MOD,
		B_SUM,
		B_UPD
	} sbim_bstate_t;

endpackage

// ===== rtl/sbim_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbim_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbim_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sbim_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbim_fifo - short request queue between front and back end
// Flip-flop storage, first-word fall-through head.
// ----------------------------------------------------------------------------
module sbim_fifo #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = mem_q[rd_ptr_q];

	// store an entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sbim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbim_front - accept and classify input items
// Registers the item with per-byte trailing-zero data of the guarded hash,
// then works out the word address, the bit mask and the error status, and
// pushes the request into the queue.
// ----------------------------------------------------------------------------
module sbim_front #(
	parameter int MAX_INDEX_BITS = 12,
	parameter int MAX_PRECISION  = 32,
	parameter int ADDR_W         = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sbim_pkg::sbim_cfg_t             cfg,
	input  logic                            clearing,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sbim_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [sbim_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            q_push,
	input  logic                            q_full,
	output logic [ADDR_W-1:0]               q_addr,
	output logic [sbim_pkg::WORD_W-1:0]     q_bits,
	output logic [sbim_pkg::ERR_W-1:0]      q_err
);

	import sbim_pkg::*;

	localparam int TOTAL = MAX_PRECISION * (1 << MAX_INDEX_BITS);
	localparam int POSW  = $clog2(TOTAL);
	localparam int NBW   = $clog2(TOTAL + 1);
	localparam int CMPW  = (NBW > 17) ? NBW : 17;
	localparam int BKT_W = MAX_INDEX_BITS;

	// input field positions in s_tdata
	localparam int HASH_LSB   = 0;
	localparam int BUCKET_LSB = 64;
	localparam int ZEROS_LSB  = 76;
	localparam int WIDX_LSB   = 83;
	localparam int MWORD_LSB  = 94;

	logic [63:0] hash_in;
	logic [63:0] guard_hash;
	logic [7:0]  byte_nz_in;
	logic [2:0]  byte_ctz_in [8];

	logic             valid_s1;
	sbim_mode_t       mode_s1;
	logic [BKT_W-1:0] bkt_h_s1;
	logic [7:0]       byte_nz_s1;
	logic [2:0]       byte_ctz_s1 [8];
	logic [11:0]      bucket_s1;
	logic [6:0]       zeros_s1;
	logic [10:0]      widx_s1;
	logic [63:0]      mword_s1;

	logic [2:0]       sel_byte;
	logic [6:0]       hash_z;
	logic [6:0]       cap;
	logic [6:0]       lvl_src;
	logic [6:0]       lvl;
	logic [BKT_W-1:0] bkt;
	logic [POSW-1:0]  pos;
	logic [NBW-1:0]   nbits;
	logic [CMPW-1:0]  widx_bit;
	logic [CMPW-1:0]  lim;
	logic [63:0]      tail_mask;
	logic             word_ok;

	assign hash_in    = s_tdata[HASH_LSB +: 64];
	assign guard_hash = hash_in | (64'd1 << 6'(7'd64 - {2'b00, cfg.ib}));

	// trailing zeros of each byte of the guarded hash
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_nz_in[k]  = |guard_hash[8*k +: 8];
			byte_ctz_in[k] = 3'd0;
			for (int j = 7; j >= 0; j--) begin
				if (guard_hash[8*k + j]) begin
					byte_ctz_in[k] = 3'(j);
				end
			end
		end
	end

	// take an item whenever no clearing pass runs and stage one is free or drains into the queue
	assign s_tready = !clearing && (!valid_s1 || !q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1     <= sbim_mode_t'(s_tuser);
			bkt_h_s1    <= BKT_W'(hash_in >> (7'd64 - {2'b00, cfg.ib}));
			byte_nz_s1  <= byte_nz_in;
			byte_ctz_s1 <= byte_ctz_in;
			bucket_s1   <= s_tdata[BUCKET_LSB +: 12];
			zeros_s1    <= s_tdata[ZEROS_LSB +: 7];
			widx_s1     <= s_tdata[WIDX_LSB +: 11];
			mword_s1    <= s_tdata[MWORD_LSB +: 64];
		end
	end

	// pick the lowest non-zero byte; the guard bit makes one always present
	always_comb begin
		sel_byte = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (byte_nz_s1[k]) begin
				sel_byte = 3'(k);
			end
		end
		hash_z = {1'b0, sel_byte, byte_ctz_s1[sel_byte]};
	end

	// level, bit position and shape of the sketch
	always_comb begin
		cap      = cfg.prec - 7'd1;
		lvl_src  = (mode_s1 == MODE_HASH) ? hash_z : zeros_s1;
		lvl      = (lvl_src > cap) ? cap : lvl_src;
		bkt      = (mode_s1 == MODE_HASH) ? bkt_h_s1 : BKT_W'(bucket_s1);
		pos      = POSW'(POSW'(lvl) << cfg.ib) + POSW'(bkt);
		nbits    = NBW'(NBW'(cfg.prec) << cfg.ib);
		widx_bit = CMPW'({widx_s1, 6'd0});
		word_ok  = widx_bit < CMPW'(nbits);
		lim      = CMPW'(nbits) - widx_bit;
		tail_mask = (lim < CMPW'(64)) ? ~(64'hFFFF_FFFF_FFFF_FFFF << lim[5:0])
			: 64'hFFFF_FFFF_FFFF_FFFF;
	end

	// build the request
	always_comb begin
		q_addr = '0;
		q_bits = '0;
		q_err  = ERR_OK;
		case (mode_s1)
			MODE_HASH: begin
				q_addr = ADDR_W'(pos >> 6);
				q_bits = 64'd1 << 6'(pos);
			end
			MODE_DIRECT: begin
				if ((bucket_s1 >> cfg.ib) != 12'd0) begin
					q_err = ERR_BUCKET;
				end else begin
					q_addr = ADDR_W'(pos >> 6);
					q_bits = 64'd1 << 6'(pos);
				end
			end
			MODE_MERGE: begin
				if (!word_ok) begin
					q_err = ERR_WORD;
				end else begin
					q_addr = ADDR_W'(widx_s1);
					q_bits = mword_s1 & tail_mask;
				end
			end
			MODE_READ: begin
				if (!word_ok) begin
					q_err = ERR_WORD;
				end else begin
					q_addr = ADDR_W'(widx_s1);
				end
			end
			default: begin
				q_err = ERR_OK;
			end
		endcase
	end

	assign q_push = valid_s1 && !q_full;

endmodule

// ===== rtl/sbim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbim_back - read-modify-write of the sketch store
// Pops a request, reads the word, ORs in the new bits, counts the fresh
// bits and keeps the running set count and highest set bit. Also runs the
// clearing pass over the store after reset and after a register write.
// ----------------------------------------------------------------------------
module sbim_back #(
	parameter int MAX_INDEX_BITS = 12,
	parameter int MAX_PRECISION  = 32,
	parameter int ADDR_W         = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear_req,
	output logic                        clearing,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic [ADDR_W-1:0]           q_addr,
	input  logic [sbim_pkg::WORD_W-1:0] q_bits,
	input  logic [sbim_pkg::ERR_W-1:0]  q_err,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbim_pkg::WORD_W-1:0] out_word,
	output logic [17:0]                 out_count,
	output logic [14:0]                 out_compact,
	output logic [sbim_pkg::ERR_W-1:0]  out_err
);

	import sbim_pkg::*;

	localparam int TOTAL = MAX_PRECISION * (1 << MAX_INDEX_BITS);
	localparam int WORDS = (TOTAL + 63) / 64;
	localparam int POSW  = $clog2(TOTAL);
	localparam int CNTW  = $clog2(TOTAL + 1);
	localparam int CPW   = (POSW + 1 > 4) ? POSW + 1 : 4;

	sbim_bstate_t state_q;
	sbim_bstate_t state_d;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [63:0]       ram_wdata;
	logic [63:0]       ram_rdata;
	logic              out_load;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] job_addr_q;
	logic [63:0]       job_bits_q;
	logic [ERR_W-1:0]  job_err_q;
	logic [63:0]       res_word_q;
	logic [3:0]        bpop_q [8];
	logic [2:0]        btop_q [8];
	logic [7:0]        bnz_q;
	logic [6:0]        pop_q;
	logic [5:0]        top_q;
	logic              fresh_any_q;
	logic [CNTW-1:0]   cnt_q;
	logic [POSW-1:0]   hi_q;
	logic              any_q;
	logic              out_valid_q;

	logic [63:0]       fresh;
	logic [63:0]       word_new;
	logic [3:0]        bpop [8];
	logic [2:0]        btop [8];
	logic [7:0]        bnz;
	logic [6:0]        pop_sum;
	logic [2:0]        top_byte;
	logic [POSW-1:0]   hb;
	logic [CNTW-1:0]   cnt_n;
	logic [POSW-1:0]   hi_n;
	logic              any_n;

	sbim_ram #(
		.WIDTH (64),
		.DEPTH (WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	assign fresh    = job_bits_q & ~ram_rdata;
	assign word_new = ram_rdata | fresh;
	assign clearing = (state_q == B_CLEAR);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store controls
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = job_addr_q;
		ram_wdata = word_new;
		out_load  = 1'b0;
		case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(WORDS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_MOD;
				end
			end
			B_MOD: begin
				ram_we  = |fresh;
				state_d = B_SUM;
			end
			B_SUM: begin
				state_d = B_UPD;
			end
			B_UPD: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_CLEAR;
			end
		endcase
		if (clear_req) begin
			state_d = B_CLEAR;
		end
	end

	// per-byte count and top bit of the fresh bits
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			bpop[k] = 4'd0;
			btop[k] = 3'd0;
			for (int j = 0; j < 8; j++) begin
				bpop[k] = bpop[k] + 4'(fresh[8*k + j]);
				if (fresh[8*k + j]) begin
					btop[k] = 3'(j);
				end
			end
			bnz[k] = |fresh[8*k +: 8];
		end
	end

	// combine the byte results
	always_comb begin
		pop_sum  = 7'd0;
		top_byte = 3'd0;
		for (int k = 0; k < 8; k++) begin
			pop_sum = pop_sum + 7'(bpop_q[k]);
			if (bnz_q[k]) begin
				top_byte = 3'(k);
			end
		end
	end

	// running counts after this request
	always_comb begin
		hb    = POSW'({job_addr_q, top_q});
		cnt_n = cnt_q + CNTW'(pop_q);
		hi_n  = hi_q;
		if (fresh_any_q && (!any_q || hb > hi_q)) begin
			hi_n = hb;
		end
		any_n = any_q | fresh_any_q;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_addr_q <= q_addr;
			job_bits_q <= q_bits;
			job_err_q  <= q_err;
		end
		if (state_q == B_MOD) begin
			res_word_q <= (job_err_q == ERR_OK) ? word_new : '0;
			bpop_q     <= bpop;
			btop_q     <= btop;
			bnz_q      <= bnz;
		end
		if (state_q == B_SUM) begin
			pop_q       <= pop_sum;
			top_q       <= {top_byte, btop_q[top_byte]};
			fresh_any_q <= |bnz_q;
		end
		if (out_load) begin
			out_word    <= res_word_q;
			out_count   <= 18'(cnt_n);
			out_compact <= any_n ? 15'((CPW'(hi_n) + CPW'(8)) >> 3) : 15'd0;
			out_err     <= job_err_q;
		end
	end

	// control registers: clear sweep, counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			hi_q        <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear_req) begin
				clr_q <= '0;
				cnt_q <= '0;
				hi_q  <= '0;
				any_q <= 1'b0;
			end else begin
				if (state_q == B_CLEAR) begin
					clr_q <= clr_q + 1'b1;
				end
				if (out_load) begin
					cnt_q <= cnt_n;
					hi_q  <= hi_n;
					any_q <= any_n;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sketch_bitmap_insert_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sketch_bitmap_insert_merge - cardinality sketch bit store with insert,
// merge and read-back
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s       | in        | s_tvalid/s_tready  | s_tdata, s_tuser (mode)
//  m       | out       | m_tvalid/m_tready  | m_tdata (word, counts, error)
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// Each item is held in the front register, then passes through the queue into the
// back-end read-modify-write sequence (pop and read, modify and write, sum
// the fresh bits, update counts); the back end takes no new request until
// the last one has left the update step, which waits on m_tready.
// After reset and after any register write the store is swept clear, one
// word a cycle (2048 words with the default parameters, whatever the
// register values); no item is taken meanwhile.
// A four-entry queue lets the front keep taking items while the back is
// busy or the result register waits on m_tready.
// ----------------------------------------------------------------------------
module sketch_bitmap_insert_merge #(
	parameter int MAX_INDEX_BITS = 12,
	parameter int MAX_PRECISION  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// hash[63:0], bucket[75:64], zeros[82:76], word_index[93:83],
	// merge_word[157:94], zero fill[159:158]
	input  logic [sbim_pkg::S_TDATA_W-1:0]    s_tdata,
	// mode[1:0]
	input  logic [sbim_pkg::S_TUSER_W-1:0]    s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_word[63:0], set_bit_count[81:64], compact_bytes[96:82],
	// error[98:97], zero fill[103:99]
	output logic [sbim_pkg::M_TDATA_W-1:0]    m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [sbim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbim_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import sbim_pkg::*;

	localparam int TOTAL  = MAX_PRECISION * (1 << MAX_INDEX_BITS);
	localparam int WORDS  = (TOTAL + 63) / 64;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int QDEPTH = 4;
	localparam int QW     = ADDR_W + WORD_W + ERR_W;

	logic [3:0]        index_bits_q;
	logic [5:0]        precision_q;
	sbim_cfg_t         cfg;
	logic              clearing;

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	logic [ADDR_W-1:0] push_addr;
	logic [WORD_W-1:0] push_bits;
	logic [ERR_W-1:0]  push_err;
	logic [QW-1:0]     head;

	logic [WORD_W-1:0] out_word;
	logic [17:0]       out_count;
	logic [14:0]       out_compact;
	logic [ERR_W-1:0]  out_err;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= 4'd12;
			precision_q  <= 6'd32;
		end else if (cfg_we) begin
			case (sbim_reg_t'(cfg_index))
				REG_INDEX_BITS: index_bits_q <= cfg_data[3:0];
				REG_PRECISION:  precision_q  <= cfg_data;
				default:        index_bits_q <= index_bits_q;
			endcase
		end
	end

	// clamp the registers into the supported shape
	always_comb begin
		if (index_bits_q == 4'd0) begin
			cfg.ib = 5'd1;
		end else if ({1'b0, index_bits_q} > 5'(MAX_INDEX_BITS)) begin
			cfg.ib = 5'(MAX_INDEX_BITS);
		end else begin
			cfg.ib = {1'b0, index_bits_q};
		end
		if (precision_q == 6'd0) begin
			cfg.prec = 7'd1;
		end else if ({1'b0, precision_q} > 7'(MAX_PRECISION)) begin
			cfg.prec = 7'(MAX_PRECISION);
		end else begin
			cfg.prec = {1'b0, precision_q};
		end
	end

	sbim_front #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS),
		.MAX_PRECISION  (MAX_PRECISION),
		.ADDR_W         (ADDR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.clearing (clearing),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_addr   (push_addr),
		.q_bits   (push_bits),
		.q_err    (push_err)
	);

	sbim_fifo #(
		.WIDTH (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_addr, push_bits, push_err}),
		.full      (q_full),
		.pop       (q_pop),
		.head_data (head),
		.empty     (q_empty)
	);

	sbim_back #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS),
		.MAX_PRECISION  (MAX_PRECISION),
		.ADDR_W         (ADDR_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_req   (cfg_we),
		.clearing    (clearing),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_addr      (head[QW-1 -: ADDR_W]),
		.q_bits      (head[ERR_W +: WORD_W]),
		.q_err       (head[ERR_W-1:0]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_word    (out_word),
		.out_count   (out_count),
		.out_compact (out_compact),
		.out_err     (out_err)
	);

	// pack the result
	assign m_tdata = {5'd0, out_err, out_compact, out_count, out_word};

	// no request is taken while the store is being swept
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("request taken during clearing pass");

	// a register write starts a sweep at once
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (clearing && !s_tready))
		else $error("register write did not start clearing pass");

	// a flagged result carries no word
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_err != ERR_OK)) |-> (out_word == '0))
		else $error("error result with non-zero word");

endmodule
